// ----- rtl/bth_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bth_pkg
// shared types and constants of the boundary tag heap allocator
// ----------------------------------------------------------------------------
package bth_pkg;

    // operation codes
    localparam logic [1:0] FUNC_INIT  = 2'd0;
    localparam logic [1:0] FUNC_ALLOC = 2'd1;
    localparam logic [1:0] FUNC_FREE  = 2'd2;

    // configuration register indexes
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK      = 1'b1;

    // configuration reset values
    localparam logic [7:0]  SCAN_LIMIT_RST = 8'd70;
    localparam logic [16:0] CHUNK_RST      = 17'd4096;

    // heap layout constants
    localparam logic [63:0] LIST_START    = 64'd8;
    localparam logic [63:0] SPLIT_MIN     = 64'd16;
    localparam logic [31:0] PROLOGUE_TAG  = 32'd9;
    localparam logic [31:0] EPILOGUE_TAG  = 32'd1;
    localparam logic [16:0] MIN_BLOCK     = 17'd16;

    // input word
    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] req_size;
        logic [15:0] block_addr;
    } t_in_word;

    // output word
    typedef struct packed {
        logic [15:0] result_addr;
        logic        status;
    } t_out_word;

endpackage
`default_nettype wire

// ----- rtl/bth_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// bth_ram
// simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module bth_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16384
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

// ----- rtl/boundary_tag_heap_allocator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator
// implicit free list allocator with header and footer tags in a word ram
// ----------------------------------------------------------------------------
// usage
//   input channel (i_in_valid / o_in_stall / i_in_word) takes one word per
//   operation: init, allocate or free. each operation gives exactly one word
//   on the output channel (o_out_valid / i_out_stall / o_out_word).
//   the configuration port (i_cfg_we / i_cfg_idx / i_cfg_data) sets the
//   extra scan limit and the growth chunk; write it only while idle.
// operation flow
//   one operation at a time; every tag access uses the single registered
//   read port of the heap ram, so each header read in a search takes a read
//   state and a check state. rejected words go straight to the finish step.
//   the next word is taken once the result sits in the output register.
// reset
//   heap_break, rover and ready clear, registers take their defaults. the
//   heap ram is not cleared; init must run before allocate or free.
// stall
//   a stalled result is held in the output register; a new operation may be
//   accepted meanwhile, and it waits for the register before it finishes.
// ----------------------------------------------------------------------------
module boundary_tag_heap_allocator #(
    parameter int HEAP_BYTES = 65536
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_stall,
    input  wire  bth_pkg::t_in_word         i_in_word,
    output logic                            o_out_valid,
    input  wire                             i_out_stall,
    output bth_pkg::t_out_word              o_out_word,
    input  wire                             i_cfg_we,
    input  wire  [bth_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [bth_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import bth_pkg::*;

    localparam int HEAP_WORDS = HEAP_BYTES / 4;
    localparam int AW         = $clog2(HEAP_WORDS);
    localparam int HB_W       = $clog2(HEAP_BYTES + 1);
    localparam int NS         = 50;

    typedef enum logic [1:0] {
        CTX_INIT  = 2'b01,
        CTX_ALLOC = 2'b10,
        CTX_FREE  = 2'b11
    } t_ctx;

    typedef enum logic [NS-1:0] {
        ST_IDLE     = 50'b1 << 0,
        ST_I_W      = 50'b1 << 1,
        ST_NF_RD    = 50'b1 << 2,
        ST_NF_CHK   = 50'b1 << 3,
        ST_IN_RD    = 50'b1 << 4,
        ST_IN_CHK   = 50'b1 << 5,
        ST_FF_TST   = 50'b1 << 6,
        ST_FF_CHK   = 50'b1 << 7,
        ST_G_CHK    = 50'b1 << 8,
        ST_G_W1     = 50'b1 << 9,
        ST_G_R1     = 50'b1 << 10,
        ST_G_W2     = 50'b1 << 11,
        ST_G_R2     = 50'b1 << 12,
        ST_G_W3     = 50'b1 << 13,
        ST_M_R0     = 50'b1 << 14,
        ST_M_R1     = 50'b1 << 15,
        ST_M_R2     = 50'b1 << 16,
        ST_M_DEC    = 50'b1 << 17,
        ST_MA_W1    = 50'b1 << 18,
        ST_MA_R1    = 50'b1 << 19,
        ST_MA_W2    = 50'b1 << 20,
        ST_MB_1     = 50'b1 << 21,
        ST_MB_R2    = 50'b1 << 22,
        ST_MB_W2    = 50'b1 << 23,
        ST_MB_R3    = 50'b1 << 24,
        ST_M_PREV   = 50'b1 << 25,
        ST_MC_1     = 50'b1 << 26,
        ST_MC_2     = 50'b1 << 27,
        ST_MC_R3    = 50'b1 << 28,
        ST_MC_W1    = 50'b1 << 29,
        ST_MC_R4    = 50'b1 << 30,
        ST_MC_R5    = 50'b1 << 31,
        ST_MC_W2    = 50'b1 << 32,
        ST_MC_R6    = 50'b1 << 33,
        ST_M_RET    = 50'b1 << 34,
        ST_P_RD     = 50'b1 << 35,
        ST_P_DEC    = 50'b1 << 36,
        ST_PN_R1    = 50'b1 << 37,
        ST_PN_W     = 50'b1 << 38,
        ST_PS_R1    = 50'b1 << 39,
        ST_PS_W1    = 50'b1 << 40,
        ST_PS_R2    = 50'b1 << 41,
        ST_PS_NB    = 50'b1 << 42,
        ST_PS_R3    = 50'b1 << 43,
        ST_PS_W3    = 50'b1 << 44,
        ST_F_RD     = 50'b1 << 45,
        ST_F_W1     = 50'b1 << 46,
        ST_F_R2     = 50'b1 << 47,
        ST_F_W2     = 50'b1 << 48,
        ST_FIN      = 50'b1 << 49
    } t_state;

    // control state
    t_state           r_state, n_state;
    logic             r_ov, n_ov;
    logic [HB_W-1:0]  r_hb, n_hb;
    logic [63:0]      r_rover, n_rover;
    logic             r_ready, n_ready;
    logic [7:0]       r_lim;
    logic [16:0]      r_chunk;

    // datapath registers
    logic [63:0]      r_bp, n_bp;
    logic [63:0]      r_best, n_best;
    logic [63:0]      r_bsz, n_bsz;
    logic [63:0]      r_t, n_t;
    logic [63:0]      r_v, n_v;
    logic [63:0]      r_s0, n_s0;
    logic [63:0]      r_size, n_size;
    logic [31:0]      r_pf, n_pf;
    logic [31:0]      r_nf, n_nf;
    logic [16:0]      r_asize, n_asize;
    logic [16:0]      r_bytes, n_bytes;
    logic [7:0]       r_i, n_i;
    logic [1:0]       r_k, n_k;
    t_ctx             r_ctx, n_ctx;
    logic [15:0]      r_res, n_res;
    logic             r_st, n_st;
    t_out_word        r_out, n_out;
    logic             r_oob;

    // memory access
    logic             wr_req, rd_req, ram_we;
    logic [63:0]      wr_a, wr_v, rd_a;
    logic [31:0]      ram_q, rdat;
    logic [63:0]      dsz;
    logic             in_acc;

    function automatic logic in_heap(input logic [63:0] a);
        return (a >> 2) < 64'(HEAP_WORDS);
    endfunction

    assign rdat   = r_oob ? 32'd0 : ram_q;
    assign dsz    = {32'd0, rdat[31:3], 3'b000};
    assign ram_we = wr_req && in_heap(wr_a);
    assign in_acc = i_in_valid && !o_in_stall;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_word  = r_out;

    bth_ram #(
        .WIDTH (32),
        .DEPTH (HEAP_WORDS)
    ) u_heap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_a[AW+1:2]),
        .i_wdata (wr_v[31:0]),
        .i_re    (rd_req),
        .i_raddr (rd_a[AW+1:2]),
        .o_rdata (ram_q)
    );

    // sequencer over the tag memory
    always_comb begin
        logic        fit;
        logic [63:0] bsz_new;
        logic [63:0] best_new;
        logic [17:0] gsize;
        logic [14:0] words;
        logic [16:0] ext;

        n_state = r_state;
        n_ov    = r_ov;
        n_hb    = r_hb;
        n_rover = r_rover;
        n_ready = r_ready;
        n_bp    = r_bp;
        n_best  = r_best;
        n_bsz   = r_bsz;
        n_t     = r_t;
        n_v     = r_v;
        n_s0    = r_s0;
        n_size  = r_size;
        n_pf    = r_pf;
        n_nf    = r_nf;
        n_asize = r_asize;
        n_bytes = r_bytes;
        n_i     = r_i;
        n_k     = r_k;
        n_ctx   = r_ctx;
        n_res   = r_res;
        n_st    = r_st;
        n_out   = r_out;
        wr_req  = 1'b0;
        wr_a    = 64'd0;
        wr_v    = 64'd0;
        rd_req  = 1'b0;
        rd_a    = 64'd0;

        fit      = !rdat[0] && ({47'd0, r_asize} <= dsz);
        bsz_new  = (fit && r_bsz > dsz) ? dsz : r_bsz;
        best_new = (fit && r_bsz > dsz) ? r_bp : r_best;
        words    = r_bytes[16:2];
        gsize    = {16'(words) + {15'd0, words[0]}, 2'b00};
        if (gsize == 18'd0) begin
            gsize = 18'd8;
        end
        ext      = (r_asize > r_chunk) ? r_asize : r_chunk;

        // output register drains
        if (r_ov && !i_out_stall) begin
            n_ov = 1'b0;
        end

        case (r_state)
            // dispatch
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_res = 16'd0;
                    case (i_in_word.func)
                        FUNC_INIT: begin
                            n_k     = 2'd0;
                            n_state = ST_I_W;
                        end
                        FUNC_ALLOC: begin
                            if (!r_ready || i_in_word.req_size == 16'd0) begin
                                n_st    = 1'b1;
                                n_state = ST_FIN;
                            end else begin
                                if (i_in_word.req_size <= 16'd8) begin
                                    n_asize = MIN_BLOCK;
                                end else begin
                                    n_asize = (17'(i_in_word.req_size) + 17'd15) & ~17'd7;
                                end
                                n_bp    = r_rover;
                                n_i     = 8'd0;
                                n_state = ST_NF_RD;
                            end
                        end
                        FUNC_FREE: begin
                            if (!r_ready) begin
                                n_st    = 1'b1;
                                n_state = ST_FIN;
                            end else if (i_in_word.block_addr == 16'd0) begin
                                n_st    = 1'b0;
                                n_state = ST_FIN;
                            end else begin
                                n_bp    = 64'(i_in_word.block_addr);
                                n_state = ST_F_RD;
                            end
                        end
                        default: begin
                            n_st    = 1'b1;
                            n_state = ST_FIN;
                        end
                    endcase
                end
            end

            // prologue and epilogue
            ST_I_W: begin
                wr_req = 1'b1;
                wr_a   = {60'd0, r_k, 2'b00};
                case (r_k)
                    2'd0:    wr_v = 64'd0;
                    2'd3:    wr_v = 64'(EPILOGUE_TAG);
                    default: wr_v = 64'(PROLOGUE_TAG);
                endcase
                if (r_k == 2'd3) begin
                    n_hb    = HB_W'(16);
                    n_rover = LIST_START;
                    n_bytes = r_chunk;
                    n_ctx   = CTX_INIT;
                    n_state = ST_G_CHK;
                end else begin
                    n_k = r_k + 2'd1;
                end
            end

            // next fit from the rover
            ST_NF_RD: begin
                rd_req  = 1'b1;
                rd_a    = r_bp - 64'd4;
                n_state = ST_NF_CHK;
            end
            ST_NF_CHK: begin
                if (dsz == 64'd0) begin
                    n_bp    = LIST_START;
                    n_state = ST_FF_TST;
                end else if (fit) begin
                    n_best  = r_bp;
                    n_bsz   = dsz;
                    n_state = ST_IN_RD;
                end else begin
                    n_bp    = r_bp + dsz;
                    n_state = ST_NF_RD;
                end
            end

            // bounded scan for a smaller fit
            ST_IN_RD: begin
                rd_req  = 1'b1;
                rd_a    = r_bp - 64'd4;
                n_state = ST_IN_CHK;
            end
            ST_IN_CHK: begin
                if (dsz == 64'd0 || r_i >= r_lim) begin
                    n_rover = r_best;
                    n_bp    = r_best;
                    n_state = ST_P_RD;
                end else if (fit && bsz_new == {47'd0, r_asize}) begin
                    n_rover = best_new;
                    n_bp    = best_new;
                    n_state = ST_P_RD;
                end else begin
                    n_best  = best_new;
                    n_bsz   = bsz_new;
                    n_i     = r_i + 8'd1;
                    n_bp    = r_bp + dsz;
                    n_state = ST_IN_RD;
                end
            end

            // first fit from the list start up to the rover
            ST_FF_TST: begin
                if (r_bp < r_rover) begin
                    rd_req  = 1'b1;
                    rd_a    = r_bp - 64'd4;
                    n_state = ST_FF_CHK;
                end else begin
                    n_bytes = ext;
                    n_ctx   = CTX_ALLOC;
                    n_state = ST_G_CHK;
                end
            end
            ST_FF_CHK: begin
                if (dsz == 64'd0) begin
                    n_bytes = ext;
                    n_ctx   = CTX_ALLOC;
                    n_state = ST_G_CHK;
                end else if (fit) begin
                    n_rover = r_bp;
                    n_state = ST_P_RD;
                end else begin
                    n_bp    = r_bp + dsz;
                    n_state = ST_FF_TST;
                end
            end

            // heap growth
            ST_G_CHK: begin
                if (64'(r_hb) + 64'(gsize) > 64'(HEAP_BYTES)) begin
                    if (r_ctx == CTX_INIT) begin
                        n_ready = 1'b0;
                    end
                    n_st    = 1'b1;
                    n_state = ST_FIN;
                end else begin
                    n_bp    = 64'(r_hb);
                    n_v     = 64'(gsize);
                    n_hb    = HB_W'(64'(r_hb) + 64'(gsize));
                    n_state = ST_G_W1;
                end
            end
            ST_G_W1: begin
                wr_req  = 1'b1;
                wr_a    = r_bp - 64'd4;
                wr_v    = r_v;
                n_state = ST_G_R1;
            end
            ST_G_R1: begin
                rd_req  = 1'b1;
                rd_a    = r_bp - 64'd4;
                n_state = ST_G_W2;
            end
            ST_G_W2: begin
                wr_req  = 1'b1;
                wr_a    = r_bp + dsz - 64'd8;
                wr_v    = r_v;
                n_state = ST_G_R2;
            end
            ST_G_R2: begin
                rd_req  = 1'b1;
                rd_a    = r_bp - 64'd4;
                n_state = ST_G_W3;
            end
            ST_G_W3: begin
                wr_req  = 1'b1;
                wr_a    = r_bp + dsz - 64'd4;
                wr_v    = 64'(EPILOGUE_TAG);
                n_state = ST_M_R0;
            end

            // merge: read neighbor tags
            ST_M_R0: begin
                rd_req  = 1'b1;
                rd_a    = r_bp - 64'd8;
                n_state = ST_M_R1;
            end
            ST_M_R1: begin
                n_pf    = rdat;
                rd_req  = 1'b1;
                rd_a    = r_bp - 64'd4;
                n_state = ST_M_R2;
            end
            ST_M_R2: begin
                n_s0    = dsz;
                rd_req  = 1'b1;
                rd_a    = r_bp + dsz - 64'd4;
                n_state = ST_M_DEC;
            end
            ST_M_DEC: begin
                n_nf = rdat;
                if (r_pf[0] && rdat[0]) begin
                    n_state = ST_M_RET;
                end else if (r_pf[0]) begin
                    n_size  = r_s0 + dsz;
                    n_state = ST_MA_W1;
                end else begin
                    rd_req  = 1'b1;
                    rd_a    = r_bp - {32'd0, r_pf[31:3], 3'b000} - 64'd4;
                    n_state = rdat[0] ? ST_MB_1 : ST_MC_1;
                end
            end

            // merge with the next block
            ST_MA_W1: begin
                wr_req  = 1'b1;
                wr_a    = r_bp - 64'd4;
                wr_v    = r_size;
                n_state = ST_MA_R1;
            end
            ST_MA_R1: begin
                rd_req  = 1'b1;
                rd_a    = r_bp - 64'd4;
                n_state = ST_MA_W2;
            end
            ST_MA_W2: begin
                wr_req  = 1'b1;
                wr_a    = r_bp + dsz - 64'd8;
                wr_v    = r_size;
                n_state = ST_M_RET;
            end

            // merge with the previous block
            ST_MB_1: begin
                n_size  = r_s0 + dsz;
                wr_req  = 1'b1;
                wr_a    = r_bp + r_s0 - 64'd8;
                wr_v    = r_s0 + dsz;
                n_state = ST_MB_R2;
            end
            ST_MB_R2: begin
                rd_req  = 1'b1;
                rd_a    = r_bp - 64'd8;
                n_state = ST_MB_W2;
            end
            ST_MB_W2: begin
                wr_req  = 1'b1;
                wr_a    = r_bp - dsz - 64'd4;
                wr_v    = r_size;
                n_state = ST_MB_R3;
            end
            ST_MB_R3: begin
                rd_req  = 1'b1;
                rd_a    = r_bp - 64'd8;
                n_state = ST_M_PREV;
            end
            ST_M_PREV: begin
                n_bp    = r_bp - dsz;
                n_state = ST_M_RET;
            end

            // merge with both neighbors
            ST_MC_1: begin
                n_size  = r_s0 + dsz;
                rd_req  = 1'b1;
                rd_a    = r_bp + r_s0 + {32'd0, r_nf[31:3], 3'b000} - 64'd8;
                n_state = ST_MC_2;
            end
            ST_MC_2: begin
                n_size  = r_size + dsz;
                n_state = ST_MC_R3;
            end
            ST_MC_R3: begin
                rd_req  = 1'b1;
                rd_a    = r_bp - 64'd8;
                n_state = ST_MC_W1;
            end
            ST_MC_W1: begin
                wr_req  = 1'b1;
                wr_a    = r_bp - dsz - 64'd4;
                wr_v    = r_size;
                n_state = ST_MC_R4;
            end
            ST_MC_R4: begin
                rd_req  = 1'b1;
                rd_a    = r_bp - 64'd4;
                n_state = ST_MC_R5;
            end
            ST_MC_R5: begin
                n_t     = r_bp + dsz;
                rd_req  = 1'b1;
                rd_a    = r_bp + dsz - 64'd4;
                n_state = ST_MC_W2;
            end
            ST_MC_W2: begin
                wr_req  = 1'b1;
                wr_a    = r_t + dsz - 64'd8;
                wr_v    = r_size;
                n_state = ST_MC_R6;
            end
            ST_MC_R6: begin
                rd_req  = 1'b1;
                rd_a    = r_bp - 64'd8;
                n_state = ST_M_PREV;
            end

            // merge done: back to the caller
            ST_M_RET: begin
                case (r_ctx)
                    CTX_INIT: begin
                        n_ready = 1'b1;
                        n_st    = 1'b0;
                        n_state = ST_FIN;
                    end
                    CTX_FREE: begin
                        n_rover = r_bp;
                        n_st    = 1'b0;
                        n_state = ST_FIN;
                    end
                    default: begin
                        n_state = ST_P_RD;
                    end
                endcase
            end

            // place the request, split off the remainder
            ST_P_RD: begin
                rd_req  = 1'b1;
                rd_a    = r_bp - 64'd4;
                n_state = ST_P_DEC;
            end
            ST_P_DEC: begin
                n_v    = dsz;
                n_res  = r_bp[15:0];
                wr_req = 1'b1;
                wr_a   = r_bp - 64'd4;
                if (dsz - {47'd0, r_asize} >= SPLIT_MIN) begin
                    wr_v    = {47'd0, r_asize | 17'd1};
                    n_state = ST_PS_R1;
                end else begin
                    wr_v    = dsz | 64'd1;
                    n_state = ST_PN_R1;
                end
            end
            ST_PN_R1: begin
                rd_req  = 1'b1;
                rd_a    = r_bp - 64'd4;
                n_state = ST_PN_W;
            end
            ST_PN_W: begin
                wr_req  = 1'b1;
                wr_a    = r_bp + dsz - 64'd8;
                wr_v    = r_v | 64'd1;
                n_st    = 1'b0;
                n_state = ST_FIN;
            end
            ST_PS_R1: begin
                rd_req  = 1'b1;
                rd_a    = r_bp - 64'd4;
                n_state = ST_PS_W1;
            end
            ST_PS_W1: begin
                wr_req  = 1'b1;
                wr_a    = r_bp + dsz - 64'd8;
                wr_v    = {47'd0, r_asize | 17'd1};
                n_state = ST_PS_R2;
            end
            ST_PS_R2: begin
                rd_req  = 1'b1;
                rd_a    = r_bp - 64'd4;
                n_state = ST_PS_NB;
            end
            ST_PS_NB: begin
                n_t     = r_bp + dsz;
                wr_req  = 1'b1;
                wr_a    = r_bp + dsz - 64'd4;
                wr_v    = r_v - {47'd0, r_asize};
                n_state = ST_PS_R3;
            end
            ST_PS_R3: begin
                rd_req  = 1'b1;
                rd_a    = r_t - 64'd4;
                n_state = ST_PS_W3;
            end
            ST_PS_W3: begin
                wr_req  = 1'b1;
                wr_a    = r_t + dsz - 64'd8;
                wr_v    = r_v - {47'd0, r_asize};
                n_st    = 1'b0;
                n_state = ST_FIN;
            end

            // free: clear the allocated bit in both tags
            ST_F_RD: begin
                rd_req  = 1'b1;
                rd_a    = r_bp - 64'd4;
                n_state = ST_F_W1;
            end
            ST_F_W1: begin
                n_v     = dsz;
                wr_req  = 1'b1;
                wr_a    = r_bp - 64'd4;
                wr_v    = dsz;
                n_state = ST_F_R2;
            end
            ST_F_R2: begin
                rd_req  = 1'b1;
                rd_a    = r_bp - 64'd4;
                n_state = ST_F_W2;
            end
            ST_F_W2: begin
                wr_req  = 1'b1;
                wr_a    = r_bp + dsz - 64'd8;
                wr_v    = r_v;
                n_ctx   = CTX_FREE;
                n_state = ST_M_R0;
            end

            // hand the result word to the output register
            ST_FIN: begin
                if (!r_ov || !i_out_stall) begin
                    n_out.result_addr = r_st ? 16'd0 : r_res;
                    n_out.status      = r_st;
                    n_ov              = 1'b1;
                    n_state           = ST_IDLE;
                end
            end

            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            r_hb    <= '0;
            r_rover <= 64'd0;
            r_ready <= 1'b0;
            r_lim   <= SCAN_LIMIT_RST;
            r_chunk <= CHUNK_RST;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
            r_hb    <= n_hb;
            r_rover <= n_rover;
            r_ready <= n_ready;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_SCAN_LIMIT: r_lim   <= i_cfg_data[7:0];
                    CFG_CHUNK:      r_chunk <= i_cfg_data;
                    default:        r_lim   <= r_lim;
                endcase
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_bp    <= n_bp;
        r_best  <= n_best;
        r_bsz   <= n_bsz;
        r_t     <= n_t;
        r_v     <= n_v;
        r_s0    <= n_s0;
        r_size  <= n_size;
        r_pf    <= n_pf;
        r_nf    <= n_nf;
        r_asize <= n_asize;
        r_bytes <= n_bytes;
        r_i     <= n_i;
        r_k     <= n_k;
        r_ctx   <= n_ctx;
        r_res   <= n_res;
        r_st    <= n_st;
        r_out   <= n_out;
        if (rd_req) begin
            r_oob <= !in_heap(rd_a);
        end
    end

    // checks
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state != ST_IDLE))
        else $error("accepted word did not start an operation");

    a_break_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        64'(r_hb) <= 64'(HEAP_BYTES))
        else $error("heap break beyond heap size");

    a_ready_break: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ready && r_state == ST_IDLE) |-> (64'(r_hb) >= 64'd24))
        else $error("heap ready without prologue and first chunk");

    a_out_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_FIN))
        else $error("result word loaded outside the finish step");

    a_no_rw_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(wr_req && rd_req))
        else $error("tag read and write issued in the same cycle");

endmodule
`default_nettype wire

// ----- verif/boundary_tag_heap_allocator_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// boundary_tag_heap_allocator_test
// self-checking bench: init, allocate, free and unknown words go in with random gaps,
// a local heap model predicts every result word, and each result leaving the
// block is compared field by field with the oldest prediction
// ----------------------------------------------------------------------------
module boundary_tag_heap_allocator_test;
    import bth_pkg::*;

    localparam int HEAP_BYTES = 65536;
    localparam int HEAP_WORDS = HEAP_BYTES / 4;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_word              i_in_word;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_word             o_out_word;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    boundary_tag_heap_allocator #(.HEAP_BYTES(HEAP_BYTES)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_word(i_in_word),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall), .o_out_word(o_out_word),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    // heap model state
    logic [31:0] heap_mem [HEAP_WORDS];
    logic [63:0] heap_brk, rover_pos, list_head;
    bit          heap_ready;
    logic [7:0]  scan_limit;
    logic [16:0] chunk_size;

    t_out_word   pending_results [$];
    int          live_blocks [$];
    int          errors;
    bit          quiet;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #80ms;
        $display("boundary_tag_heap_allocator: mismatch");
        $finish;
    end

    // tag access helpers
    function automatic logic [31:0] tag_rd(logic [63:0] a);
        logic [63:0] w;
        w = a >> 2;
        return (w < HEAP_WORDS) ? heap_mem[w] : 32'd0;
    endfunction

    function automatic void tag_wr(logic [63:0] a, logic [63:0] v);
        logic [63:0] w;
        w = a >> 2;
        if (w < HEAP_WORDS) heap_mem[w] = v[31:0];
    endfunction

    function automatic logic [63:0] blk_size(logic [63:0] bp);
        return {32'd0, tag_rd(bp - 4) & ~32'd7};
    endfunction

    function automatic bit blk_used(logic [63:0] bp);
        return tag_rd(bp - 4) & 32'd1;
    endfunction

    function automatic logic [63:0] blk_ftr(logic [63:0] bp);
        return bp + blk_size(bp) - 8;
    endfunction

    function automatic logic [63:0] blk_next(logic [63:0] bp);
        return bp + blk_size(bp);
    endfunction

    function automatic logic [63:0] blk_prev(logic [63:0] bp);
        return bp - {32'd0, tag_rd(bp - 8) & ~32'd7};
    endfunction

    // join a free block with free neighbours
    function automatic logic [63:0] coalesce(logic [63:0] bp);
        bit          pa, na;
        logic [63:0] sz;
        pa = tag_rd(bp - 8) & 32'd1;
        na = tag_rd(blk_ftr(bp) + 4) & 32'd1;
        sz = blk_size(bp);
        if (pa && na) return bp;
        if (pa) begin
            sz += blk_size(blk_next(bp));
            tag_wr(bp - 4, sz);
            tag_wr(blk_ftr(bp), sz);
        end else if (na) begin
            sz += blk_size(blk_prev(bp));
            tag_wr(blk_ftr(bp), sz);
            tag_wr(blk_prev(bp) - 4, sz);
            bp = blk_prev(bp);
        end else begin
            sz += blk_size(blk_prev(bp)) + {32'd0, tag_rd(blk_ftr(blk_next(bp))) & ~32'd7};
            tag_wr(blk_prev(bp) - 4, sz);
            tag_wr(blk_ftr(blk_next(bp)), sz);
            bp = blk_prev(bp);
        end
        return bp;
    endfunction

    function automatic bit extend_heap(logic [63:0] bytes, output logic [63:0] bp);
        logic [63:0] words, sz;
        words = bytes >> 2;
        sz = words[0] ? (words + 1) * 4 : words * 4;
        if (sz == 0) sz = 8;
        bp = 0;
        if (heap_brk + sz > HEAP_BYTES) return 0;
        bp = heap_brk;
        heap_brk += sz;
        tag_wr(bp - 4, sz);
        tag_wr(blk_ftr(bp), sz);
        tag_wr(blk_next(bp) - 4, 1);
        bp = coalesce(bp);
        return 1;
    endfunction

    function automatic void place_block(logic [63:0] bp, logic [63:0] asize);
        logic [63:0] csize;
        csize = blk_size(bp);
        if (csize - asize >= SPLIT_MIN) begin
            tag_wr(bp - 4, asize | 1);
            tag_wr(blk_ftr(bp), asize | 1);
            bp = blk_next(bp);
            tag_wr(bp - 4, csize - asize);
            tag_wr(blk_ftr(bp), csize - asize);
        end else begin
            tag_wr(bp - 4, csize | 1);
            tag_wr(blk_ftr(bp), csize | 1);
        end
    endfunction

    // next fit with a bounded best-fit look-ahead, then first fit up to rover
    function automatic bit locate_fit(logic [63:0] asize, output logic [63:0] found);
        logic [63:0] bp, best;
        int          i;
        i = 0;
        found = 0;
        for (bp = rover_pos; blk_size(bp) > 0; bp = blk_next(bp)) begin
            if (!blk_used(bp) && asize <= blk_size(bp)) begin
                best = bp;
                for (; blk_size(bp) > 0 && i < scan_limit; i++, bp = blk_next(bp)) begin
                    if (!blk_used(bp) && asize <= blk_size(bp)) begin
                        if (blk_size(best) > blk_size(bp)) best = bp;
                        if (blk_size(best) == asize) break;
                    end
                end
                rover_pos = best;
                found = best;
                return 1;
            end
        end
        for (bp = list_head; bp < rover_pos; bp = blk_next(bp)) begin
            if (blk_size(bp) == 0) break;
            if (!blk_used(bp) && asize <= blk_size(bp)) begin
                rover_pos = bp;
                found = bp;
                return 1;
            end
        end
        return 0;
    endfunction

    // expected result word of one operation
    function automatic t_out_word heap_predict(t_in_word w);
        t_out_word   r;
        logic [63:0] bp, asize, ext, sz, req, addr;
        bit          ok;
        r.result_addr = '0;
        r.status = 1'b1;
        req = {48'd0, w.req_size};
        addr = {48'd0, w.block_addr};
        case (w.func)
            FUNC_INIT: begin
                heap_brk = 0;
                tag_wr(0, 0);
                tag_wr(4, PROLOGUE_TAG);
                tag_wr(8, PROLOGUE_TAG);
                tag_wr(12, EPILOGUE_TAG);
                heap_brk = 16;
                list_head = LIST_START;
                rover_pos = LIST_START;
                heap_ready = extend_heap({47'd0, chunk_size}, bp);
                r.status = !heap_ready;
            end
            FUNC_ALLOC: begin
                if (heap_ready && req != 0) begin
                    asize = (req <= 8) ? 64'd16 : 8 * ((req + 15) / 8);
                    ok = locate_fit(asize, bp);
                    if (!ok) begin
                        ext = (asize > chunk_size) ? asize : {47'd0, chunk_size};
                        ok = extend_heap(ext, bp);
                    end
                    if (ok) begin
                        place_block(bp, asize);
                        r.result_addr = bp[15:0];
                        r.status = 1'b0;
                    end
                end
            end
            FUNC_FREE: begin
                if (heap_ready) begin
                    r.status = 1'b0;
                    if (addr != 0) begin
                        sz = blk_size(addr);
                        tag_wr(addr - 4, sz);
                        tag_wr(blk_ftr(addr), sz);
                        rover_pos = coalesce(addr);
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // result checker and output stall
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    $display("%t unexpected word: actual %h", $realtime, o_out_word);
                    errors++;
                end else begin
                    exp_w = pending_results.pop_front();
                    if (exp_w.result_addr !== o_out_word.result_addr) begin
                        $display("%t result_addr: expected %h actual %h", $realtime,
                                 exp_w.result_addr, o_out_word.result_addr);
                        errors++;
                    end
                    if (exp_w.status !== o_out_word.status) begin
                        $display("%t status: expected %b actual %b", $realtime,
                                 exp_w.status, o_out_word.status);
                        errors++;
                    end
                end
            end
            i_out_stall <= !quiet && ($urandom_range(0, 99) < 13);
        end
    end

    // send one word; valid stays high for a following word
    task automatic send_word(logic [1:0] func, logic [15:0] req, logic [15:0] addr);
        t_in_word  w;
        t_out_word r;
        w.func = func;
        w.req_size = req;
        w.block_addr = addr;
        if (!quiet && $urandom_range(0, 99) < 13) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word <= w;
        do @(posedge i_clk); while (o_in_stall);
        r = heap_predict(w);
        pending_results.push_back(r);
        if (func == FUNC_INIT) live_blocks.delete();
        if (func == FUNC_ALLOC && r.status == 1'b0) live_blocks.push_back(r.result_addr);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending_results.size() > 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SCAN_LIMIT) scan_limit = data[7:0];
        else chunk_size = data;
    endtask

    task automatic free_random();
        int k;
        k = $urandom_range(0, live_blocks.size() - 1);
        send_word(FUNC_FREE, $urandom, live_blocks[k]);
        live_blocks.delete(k);
    endtask

    // operations before any init, unknown func, zero request
    task automatic test_not_ready();
        send_word(FUNC_ALLOC, 16'd24, 16'd0);
        send_word(FUNC_FREE, 16'd0, 16'd0);
        send_word(FUNC_FREE, 16'hffff, 16'd0);
        send_word(2'd3, 16'hffff, 16'hffff);
        send_word(FUNC_INIT, 16'd0, 16'd0);
        send_word(FUNC_ALLOC, 16'd0, 16'd0);
        send_word(2'd3, 16'd0, 16'd0);
    endtask

    // size extremes, free of none, exact fit, bit 15 of an address
    task automatic test_directed();
        send_word(FUNC_ALLOC, 16'd1, 16'd0);
        send_word(FUNC_ALLOC, 16'd8, 16'd0);
        send_word(FUNC_ALLOC, 16'd9, 16'd0);
        send_word(FUNC_ALLOC, 16'hffff, 16'd0);
        send_word(FUNC_FREE, 16'd0, 16'd0);
        free_random();
        send_word(FUNC_ALLOC, 16'd8, 16'd0);
        write_reg(CFG_CHUNK, 17'd8);
        send_word(FUNC_INIT, 16'd0, 16'd0);
        send_word(FUNC_ALLOC, 16'd33000, 16'd0);
        send_word(FUNC_ALLOC, 16'd100, 16'd0);
        send_word(FUNC_ALLOC, 16'd30000, 16'd0);
        while (live_blocks.size() > 0) free_random();
        send_word(FUNC_ALLOC, 16'd64000, 16'd0);
    endtask

    // register extremes: no look-ahead, maximal look-ahead, failing init
    task automatic test_reg_extremes();
        write_reg(CFG_SCAN_LIMIT, 17'd0);
        write_reg(CFG_CHUNK, 17'd65536);
        send_word(FUNC_INIT, 16'd0, 16'd0);
        send_word(FUNC_ALLOC, 16'd16, 16'd0);
        write_reg(CFG_CHUNK, 17'd65520);
        send_word(FUNC_INIT, 16'd0, 16'd0);
        send_word(FUNC_ALLOC, 16'd40, 16'd0);
        write_reg(CFG_SCAN_LIMIT, 17'd255);
        write_reg(CFG_CHUNK, 17'd13);
        send_word(FUNC_INIT, 16'd0, 16'd0);
        send_word(FUNC_ALLOC, 16'd200, 16'd0);
    endtask

    // random phases, each with fresh registers and a rebuilt heap
    task automatic test_random_heap();
        int          n, p;
        logic [15:0] req;
        for (int phase = 0; phase < 7; phase++) begin
            quiet = (phase == 3);
            write_reg(CFG_SCAN_LIMIT, $urandom_range(0, 255));
            p = $urandom_range(0, 9);
            write_reg(CFG_CHUNK, (p == 0) ? $urandom_range(8, 65536) :
                                            $urandom_range(8, 4096));
            send_word(FUNC_INIT, $urandom, $urandom);
            for (n = 0; n < 145; n++) begin
                p = $urandom_range(0, 99);
                if (p < 2) begin
                    send_word(2'd3, $urandom, $urandom);
                end else if (p < 4) begin
                    send_word(FUNC_INIT, $urandom, $urandom);
                end else if (p < 6) begin
                    send_word(FUNC_FREE, $urandom, 16'd0);
                end else if ((p < 45 && live_blocks.size() > 0) || live_blocks.size() > 50) begin
                    free_random();
                end else begin
                    case ($urandom_range(0, 9))
                        0:       req = $urandom;
                        1:       req = $urandom_range(0, 16);
                        2, 3:    req = $urandom_range(1, 2048);
                        default: req = $urandom_range(1, 200);
                    endcase
                    send_word(FUNC_ALLOC, req, $urandom);
                end
            end
        end
        quiet = 1'b0;
    endtask

    initial begin
        errors = 0;
        quiet = 1'b0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_word = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        heap_brk = 0;
        rover_pos = 0;
        list_head = 0;
        heap_ready = 0;
        scan_limit = SCAN_LIMIT_RST;
        chunk_size = CHUNK_RST;
        foreach (heap_mem[i]) heap_mem[i] = 32'd0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_not_ready();
        test_directed();
        test_reg_extremes();
        test_random_heap();
        drain();

        if (errors == 0 && pending_results.size() == 0) begin
            $display("boundary_tag_heap_allocator: match");
        end else begin
            $display("boundary_tag_heap_allocator: mismatch");
        end
        $finish;
    end

endmodule
